FILE: rtl/pgcd_pkg.sv
// ----------------------------------------------------------------------------
// pgcd_pkg
// Types and constants shared by the polynomial gcd block over GF(p).
// ----------------------------------------------------------------------------
package pgcd_pkg;

  localparam int unsigned CoefW  = 16;
  localparam int unsigned IndexW = 6;
  localparam int unsigned ProdW  = 2 * CoefW;
  // product bits folded into the remainder per cycle
  localparam int unsigned RedBits  = 4;
  localparam int unsigned RedSteps = ProdW / RedBits;

  typedef enum logic [26:0] {
    S_IDLE   = 27'd1 << 0,
    S_MULP   = 27'd1 << 1,
    S_MULR   = 27'd1 << 2,
    S_LDA    = 27'd1 << 3,
    S_LDB    = 27'd1 << 4,
    S_CHK    = 27'd1 << 5,
    S_RR_RD  = 27'd1 << 6,
    S_RR_W   = 27'd1 << 7,
    S_RR_A   = 27'd1 << 8,
    S_RR_B   = 27'd1 << 9,
    S_TR     = 27'd1 << 10,
    S_TR_W   = 27'd1 << 11,
    S_INIT1  = 27'd1 << 12,
    S_INIT2  = 27'd1 << 13,
    S_LOOP   = 27'd1 << 14,
    S_INV_W  = 27'd1 << 15,
    S_POW    = 27'd1 << 16,
    S_POW_R  = 27'd1 << 17,
    S_POW_B  = 27'd1 << 18,
    S_DIV    = 27'd1 << 19,
    S_DIV_W  = 27'd1 << 20,
    S_DIV_A  = 27'd1 << 21,
    S_SUB_RD = 27'd1 << 22,
    S_SUB_W  = 27'd1 << 23,
    S_SUB_WR = 27'd1 << 24,
    S_EM_RD  = 27'd1 << 25,
    S_EM_OUT = 27'd1 << 26
  } state_e;

endpackage

FILE: rtl/poly_gcd_mod_p.sv
// ----------------------------------------------------------------------------
// poly_gcd_mod_p
// Euclidean gcd of two polynomials over GF(p), coefficients held in two
// single-port-read memories, one for each operand.
// ----------------------------------------------------------------------------
// usage
//   load: one word per start pulse (start high while busy low) carries the
//   coefficients of A and B at coef_index_i. each is reduced modulo p by the
//   shared multiply-reduce unit while busy stays high.
//   the word with last_coef_i set launches the gcd: every stored coefficient
//   is reduced again with the current p, both operands are trimmed, then the
//   remainder sequence runs. every modular product is one multiply step and
//   eight steps folding four product bits each, and a memory read comes
//   before those on stored coefficients; the inverse of each divisor lead is
//   a square-and-multiply over the bits of the 16-bit p-2.
//   results: one word per gcd coefficient from x^0 upward, never back to
//   back, each shown for one cycle with out_valid_o; the receiver cannot stall.
//   a zero gcd gives a single word with zero_result_o set.
//   reset clears the stores at once (valid bits), p returns to 2.
//   the user writes prime_modulus only while busy is low; the block does not enforce it.
module poly_gcd_mod_p #(
  parameter int unsigned MAX_COEFS = 64
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          prime_modulus_we_i,
  input  logic [pgcd_pkg::CoefW-1:0]    prime_modulus_i,
  input  logic                          start,
  output logic                          busy,
  input  logic [pgcd_pkg::IndexW-1:0]   coef_index_i,
  input  logic [pgcd_pkg::CoefW-1:0]    a_coef_i,
  input  logic [pgcd_pkg::CoefW-1:0]    b_coef_i,
  input  logic                          last_coef_i,
  output logic                          out_valid_o,
  output logic [pgcd_pkg::IndexW-1:0]   out_index_o,
  output logic [pgcd_pkg::CoefW-1:0]    out_coef_o,
  output logic                          out_last_o,
  output logic                          zero_result_o
);

  localparam int unsigned AW = $clog2(MAX_COEFS);
  localparam int unsigned NW = $clog2(MAX_COEFS + 1);
  localparam int unsigned CW = pgcd_pkg::CoefW;

  pgcd_pkg::state_e state_q, state_d, ret_q, ret_d;

  logic [CW-1:0]   prime_q;
  logic [CW-1:0]   pm;
  logic [CW-1:0]   mul_a_q, mul_a_d, mul_b_q, mul_b_d;
  logic [pgcd_pkg::ProdW-1:0] prod_q, prod_d;
  logic [CW-1:0]   rem_q, rem_d;
  logic [$clog2(pgcd_pkg::RedSteps)-1:0] step_q, step_d;
  logic [pgcd_pkg::IndexW-1:0] idx_q;
  logic [CW-1:0]   inb_q;
  logic            last_q;
  logic            idx_ok;
  logic [NW-1:0]   ld_deg_q, ld_deg_d;
  logic [NW-1:0]   cnt_q, cnt_d;
  logic [NW-1:0]   nx_q, nx_d, ny_q, ny_d;
  logic            sel_q, sel_d;
  logic [CW-1:0]   inv_q, inv_d, a_q, a_d, pb_q, pb_d, pe_q, pe_d;
  logic            clr;

  // memory ports, index 0 is the store of A and 1 the store of B
  logic [CW-1:0]   mem0_q [MAX_COEFS];
  logic [CW-1:0]   mem1_q [MAX_COEFS];
  logic [MAX_COEFS-1:0] v0_q, v1_q;
  logic [1:0]      we, re;
  logic [AW-1:0]   wa [2];
  logic [AW-1:0]   ra [2];
  logic [CW-1:0]   wd [2];
  logic [CW-1:0]   rd0_q, rd1_q;
  logic            rv0_q, rv1_q;
  logic [CW-1:0]   d0, d1, rdx, rdy;
  logic [CW-1:0]   diff;

  logic            ov_d;
  logic [pgcd_pkg::IndexW-1:0] oi_d;
  logic [CW-1:0]   oc_d;
  logic            ol_d, oz_d;

  assign pm     = (prime_q < CW'(2)) ? CW'(2) : prime_q;
  assign busy   = (state_q != pgcd_pkg::S_IDLE);
  assign idx_ok = 32'(coef_index_i) < 32'(MAX_COEFS);

  assign d0  = rv0_q ? rd0_q : '0;
  assign d1  = rv1_q ? rd1_q : '0;
  assign rdx = sel_q ? d1 : d0;
  assign rdy = sel_q ? d0 : d1;
  // x - a*y mod p, both terms already below p
  assign diff = (rdx >= rem_q) ? (rdx - rem_q)
                               : CW'(17'(rdx) + 17'(pm) - 17'(rem_q));

  always_comb begin
    logic [CW:0]   r;
    logic [pgcd_pkg::ProdW-1:0] pr;
    logic [NW-1:0] sh;
    state_d  = state_q;
    ret_d    = ret_q;
    mul_a_d  = mul_a_q;
    mul_b_d  = mul_b_q;
    prod_d   = prod_q;
    rem_d    = rem_q;
    step_d   = step_q;
    ld_deg_d = ld_deg_q;
    cnt_d    = cnt_q;
    nx_d     = nx_q;
    ny_d     = ny_q;
    sel_d    = sel_q;
    inv_d    = inv_q;
    a_d      = a_q;
    pb_d     = pb_q;
    pe_d     = pe_q;
    clr      = 1'b0;
    we       = '0;
    re       = '0;
    wa[0]    = '0;
    wa[1]    = '0;
    ra[0]    = '0;
    ra[1]    = '0;
    wd[0]    = '0;
    wd[1]    = '0;
    ov_d     = 1'b0;
    oi_d     = '0;
    oc_d     = '0;
    ol_d     = 1'b0;
    oz_d     = 1'b0;
    r        = '0;
    pr       = prod_q;
    sh       = nx_q - ny_q;

    case (state_q)
      pgcd_pkg::S_IDLE: begin
        if (start) begin
          if (idx_ok) begin
            mul_a_d = a_coef_i;
            mul_b_d = CW'(1);
            ret_d   = pgcd_pkg::S_LDA;
            state_d = pgcd_pkg::S_MULP;
          end else begin
            state_d = pgcd_pkg::S_CHK;
          end
        end
      end
      pgcd_pkg::S_MULP: begin
        prod_d  = 32'(mul_a_q) * 32'(mul_b_q);
        rem_d   = '0;
        step_d  = '0;
        state_d = pgcd_pkg::S_MULR;
      end
      pgcd_pkg::S_MULR: begin
        r = {1'b0, rem_q};
        for (int k = 0; k < int'(pgcd_pkg::RedBits); k++) begin
          r  = {r[CW-1:0], pr[pgcd_pkg::ProdW-1]};
          pr = pr << 1;
          if (r >= {1'b0, pm}) r = r - {1'b0, pm};
        end
        rem_d  = r[CW-1:0];
        prod_d = pr;
        step_d = step_q + 1'b1;
        if (step_q == '1) state_d = ret_q;
      end
      pgcd_pkg::S_LDA: begin
        we[0]   = 1'b1;
        wa[0]   = AW'(idx_q);
        wd[0]   = rem_q;
        mul_a_d = inb_q;
        mul_b_d = CW'(1);
        ret_d   = pgcd_pkg::S_LDB;
        state_d = pgcd_pkg::S_MULP;
      end
      pgcd_pkg::S_LDB: begin
        we[1] = 1'b1;
        wa[1] = AW'(idx_q);
        wd[1] = rem_q;
        if (NW'(idx_q) + 1'b1 > ld_deg_q) ld_deg_d = NW'(idx_q) + 1'b1;
        state_d = pgcd_pkg::S_CHK;
      end
      pgcd_pkg::S_CHK: begin
        cnt_d   = '0;
        state_d = last_q ? pgcd_pkg::S_RR_RD : pgcd_pkg::S_IDLE;
      end
      // reduce again with the current p
      pgcd_pkg::S_RR_RD: begin
        if (cnt_q == ld_deg_q) begin
          nx_d    = ld_deg_q;
          ny_d    = ld_deg_q;
          sel_d   = 1'b0;
          ret_d   = pgcd_pkg::S_INIT1;
          state_d = pgcd_pkg::S_TR;
        end else begin
          re      = 2'b11;
          ra[0]   = cnt_q[AW-1:0];
          ra[1]   = cnt_q[AW-1:0];
          state_d = pgcd_pkg::S_RR_W;
        end
      end
      pgcd_pkg::S_RR_W: begin
        mul_a_d = d0;
        mul_b_d = CW'(1);
        ret_d   = pgcd_pkg::S_RR_A;
        state_d = pgcd_pkg::S_MULP;
      end
      pgcd_pkg::S_RR_A: begin
        we[0]   = 1'b1;
        wa[0]   = cnt_q[AW-1:0];
        wd[0]   = rem_q;
        mul_a_d = d1;
        mul_b_d = CW'(1);
        ret_d   = pgcd_pkg::S_RR_B;
        state_d = pgcd_pkg::S_MULP;
      end
      pgcd_pkg::S_RR_B: begin
        we[1]   = 1'b1;
        wa[1]   = cnt_q[AW-1:0];
        wd[1]   = rem_q;
        cnt_d   = cnt_q + 1'b1;
        state_d = pgcd_pkg::S_RR_RD;
      end
      // drop leading zeros of x
      pgcd_pkg::S_TR: begin
        if (nx_q == '0) begin
          state_d = ret_q;
        end else begin
          re[sel_q] = 1'b1;
          ra[sel_q] = AW'(nx_q - 1'b1);
          state_d   = pgcd_pkg::S_TR_W;
        end
      end
      pgcd_pkg::S_TR_W: begin
        if (rdx == '0) begin
          nx_d    = nx_q - 1'b1;
          state_d = pgcd_pkg::S_TR;
        end else begin
          state_d = ret_q;
        end
      end
      pgcd_pkg::S_INIT1: begin
        sel_d   = 1'b1;
        nx_d    = ny_q;
        ny_d    = nx_q;
        ret_d   = pgcd_pkg::S_INIT2;
        state_d = pgcd_pkg::S_TR;
      end
      pgcd_pkg::S_INIT2: begin
        // A stays the dividend unless it is the shorter one
        if (!(ny_q < nx_q)) begin
          sel_d = 1'b0;
          nx_d  = ny_q;
          ny_d  = nx_q;
        end
        state_d = pgcd_pkg::S_LOOP;
      end
      pgcd_pkg::S_LOOP: begin
        if (ny_q == '0) begin
          if (nx_q == '0) begin
            ov_d    = 1'b1;
            ol_d    = 1'b1;
            oz_d    = 1'b1;
            clr     = 1'b1;
            state_d = pgcd_pkg::S_IDLE;
          end else begin
            cnt_d   = '0;
            state_d = pgcd_pkg::S_EM_RD;
          end
        end else begin
          re[!sel_q] = 1'b1;
          ra[!sel_q] = AW'(ny_q - 1'b1);
          state_d    = pgcd_pkg::S_INV_W;
        end
      end
      pgcd_pkg::S_INV_W: begin
        pb_d    = rdy;
        inv_d   = CW'(1);
        pe_d    = pm - CW'(2);
        state_d = pgcd_pkg::S_POW;
      end
      // lead^(p-2), exponent bits from the bottom
      pgcd_pkg::S_POW: begin
        if (pe_q == '0) begin
          state_d = pgcd_pkg::S_DIV;
        end else if (pe_q[0]) begin
          mul_a_d = inv_q;
          mul_b_d = pb_q;
          ret_d   = pgcd_pkg::S_POW_R;
          state_d = pgcd_pkg::S_MULP;
        end else begin
          mul_a_d = pb_q;
          mul_b_d = pb_q;
          ret_d   = pgcd_pkg::S_POW_B;
          state_d = pgcd_pkg::S_MULP;
        end
      end
      pgcd_pkg::S_POW_R: begin
        inv_d   = rem_q;
        mul_a_d = pb_q;
        mul_b_d = pb_q;
        ret_d   = pgcd_pkg::S_POW_B;
        state_d = pgcd_pkg::S_MULP;
      end
      pgcd_pkg::S_POW_B: begin
        pb_d    = rem_q;
        pe_d    = pe_q >> 1;
        state_d = pgcd_pkg::S_POW;
      end
      pgcd_pkg::S_DIV: begin
        if (nx_q >= ny_q && nx_q != '0) begin
          re[sel_q] = 1'b1;
          ra[sel_q] = AW'(nx_q - 1'b1);
          state_d   = pgcd_pkg::S_DIV_W;
        end else begin
          sel_d   = !sel_q;
          nx_d    = ny_q;
          ny_d    = nx_q;
          state_d = pgcd_pkg::S_LOOP;
        end
      end
      pgcd_pkg::S_DIV_W: begin
        mul_a_d = rdx;
        mul_b_d = inv_q;
        ret_d   = pgcd_pkg::S_DIV_A;
        state_d = pgcd_pkg::S_MULP;
      end
      pgcd_pkg::S_DIV_A: begin
        a_d     = rem_q;
        cnt_d   = '0;
        state_d = pgcd_pkg::S_SUB_RD;
      end
      pgcd_pkg::S_SUB_RD: begin
        if (cnt_q + 1'b1 < ny_q) begin
          re         = 2'b11;
          ra[sel_q]  = AW'(sh + cnt_q);
          ra[!sel_q] = cnt_q[AW-1:0];
          state_d    = pgcd_pkg::S_SUB_W;
        end else begin
          we[sel_q] = 1'b1;
          wa[sel_q] = AW'(nx_q - 1'b1);
          wd[sel_q] = '0;
          nx_d      = nx_q - 1'b1;
          ret_d     = pgcd_pkg::S_DIV;
          state_d   = pgcd_pkg::S_TR;
        end
      end
      pgcd_pkg::S_SUB_W: begin
        mul_a_d = a_q;
        mul_b_d = rdy;
        ret_d   = pgcd_pkg::S_SUB_WR;
        state_d = pgcd_pkg::S_MULP;
      end
      pgcd_pkg::S_SUB_WR: begin
        we[sel_q] = 1'b1;
        wa[sel_q] = AW'(sh + cnt_q);
        wd[sel_q] = diff;
        cnt_d     = cnt_q + 1'b1;
        state_d   = pgcd_pkg::S_SUB_RD;
      end
      pgcd_pkg::S_EM_RD: begin
        re[sel_q] = 1'b1;
        ra[sel_q] = cnt_q[AW-1:0];
        state_d   = pgcd_pkg::S_EM_OUT;
      end
      pgcd_pkg::S_EM_OUT: begin
        ov_d  = 1'b1;
        oi_d  = pgcd_pkg::IndexW'(cnt_q);
        oc_d  = rdx;
        ol_d  = (cnt_q + 1'b1 == nx_q);
        cnt_d = cnt_q + 1'b1;
        if (cnt_q + 1'b1 == nx_q) begin
          clr     = 1'b1;
          state_d = pgcd_pkg::S_IDLE;
        end else begin
          state_d = pgcd_pkg::S_EM_RD;
        end
      end
      default: begin
        state_d = pgcd_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= pgcd_pkg::S_IDLE;
      ret_q       <= pgcd_pkg::S_IDLE;
      prime_q     <= CW'(2);
      ld_deg_q    <= '0;
      v0_q        <= '0;
      v1_q        <= '0;
      inv_q       <= '0;
      out_valid_o <= 1'b0;
    end else begin
      state_q     <= state_d;
      ret_q       <= ret_d;
      inv_q       <= inv_d;
      out_valid_o <= ov_d;
      if (prime_modulus_we_i) prime_q <= prime_modulus_i;
      if (clr) begin
        ld_deg_q <= '0;
        v0_q     <= '0;
        v1_q     <= '0;
      end else begin
        ld_deg_q <= ld_deg_d;
        if (we[0]) v0_q[wa[0]] <= 1'b1;
        if (we[1]) v1_q[wa[1]] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    mul_a_q <= mul_a_d;
    mul_b_q <= mul_b_d;
    prod_q  <= prod_d;
    rem_q   <= rem_d;
    step_q  <= step_d;
    cnt_q   <= cnt_d;
    nx_q    <= nx_d;
    ny_q    <= ny_d;
    sel_q   <= sel_d;
    a_q     <= a_d;
    pb_q    <= pb_d;
    pe_q    <= pe_d;
    if (start && !busy) begin
      idx_q  <= coef_index_i;
      inb_q  <= b_coef_i;
      last_q <= last_coef_i;
    end
    if (ov_d) begin
      out_index_o   <= oi_d;
      out_coef_o    <= oc_d;
      out_last_o    <= ol_d;
      zero_result_o <= oz_d;
    end
  end

  // coefficient stores, read data registered
  always_ff @(posedge clk_i) begin
    if (we[0]) mem0_q[wa[0]] <= wd[0];
    if (re[0]) begin
      rd0_q <= mem0_q[ra[0]];
      rv0_q <= v0_q[ra[0]];
    end
  end

  always_ff @(posedge clk_i) begin
    if (we[1]) mem1_q[wa[1]] <= wd[1];
    if (re[1]) begin
      rd1_q <= mem1_q[ra[1]];
      rv1_q <= v1_q[ra[1]];
    end
  end

  a_start_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy |=> busy)
    else $error("accepted word did not raise busy");

  a_zero_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && zero_result_o |-> out_last_o && out_coef_o == '0 && out_index_o == '0)
    else $error("zero gcd word malformed");

  a_emit_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_last_o |=> !out_valid_o && busy)
    else $error("result words not spaced or block left busy early");

endmodule
